>>> hw/rtl/quadratic_probe_hash_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic probe hash table
// Concurrent checks clocked on clk_i, off while rst_ni is low; empty when
// SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Plain property check.
`define QPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define QPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `QPHT_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define QPHT_ASSERT(lbl, prop, msg)
`define QPHT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types, codes and field widths of the quadratic probe hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpht_pkg;

  localparam int KEY_W  = 31;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 10;
  localparam int OCC_W  = 11;
  localparam int CFG_W  = 11;
  localparam int TAG_W  = 2;
  localparam int BIT_W  = 5;   // bit counter of the serial modulo

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd11;
  localparam logic [BIT_W-1:0] KEY_MSB   = 5'd30;

  // request kinds
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // slot tags
  localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
  localparam logic [TAG_W-1:0] TAG_USED    = 2'd1;
  localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [OCC_W-1:0]  occupied;
  } res_t;

  // write strobes from the sequencer to the slot store
  typedef struct packed {
    logic             tag_we;
    logic             key_we;
    logic [TAG_W-1:0] tag;
  } store_wr_t;

  typedef enum logic [2:0] {
    QPHT_CLEAR,
    QPHT_IDLE,
    QPHT_DIV,
    QPHT_READ,
    QPHT_CHECK,
    QPHT_ADV
  } qpht_state_e;

endpackage

>>> hw/rtl/qpht_modadd.sv
// ----------------------------------------------------------------------------
// qpht_modadd
// Shared modular adder: (a + b + cin) mod cap for a + b + cin below 2*cap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpht_modadd #(
  parameter int W = 11
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         cin_i,
  input  logic [W-1:0] cap_i,
  output logic [W-1:0] sum_o
);

  logic [W:0] raw;
  logic [W:0] red;

  assign raw = {1'b0, a_i} + {1'b0, b_i} + {{W{1'b0}}, cin_i};
  assign red = raw - {1'b0, cap_i};

  // one conditional subtract is enough given the operand bound
  assign sum_o = (raw >= {1'b0, cap_i}) ? red[W-1:0] : raw[W-1:0];

endmodule

>>> hw/rtl/qpht_store.sv
// ----------------------------------------------------------------------------
// qpht_store
// Slot tag and key memories; one address, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpht_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                          clk_i,
  input  qpht_pkg::store_wr_t           wr_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [qpht_pkg::KEY_W-1:0]    wkey_i,
  output logic [qpht_pkg::TAG_W-1:0]    rd_tag_o,
  output logic [qpht_pkg::KEY_W-1:0]    rd_key_o
);

  logic [qpht_pkg::TAG_W-1:0] tag_mem [DEPTH];
  logic [qpht_pkg::KEY_W-1:0] key_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.tag_we) begin
      tag_mem[addr_i] <= wr_i.tag;
    end
    rd_tag_o <= tag_mem[addr_i];
  end

  // keys are never cleared; they are only compared behind a used tag
  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[addr_i] <= wkey_i;
    end
    rd_key_o <= key_mem[addr_i];
  end

endmodule

>>> hw/rtl/qpht_seq.sv
// ----------------------------------------------------------------------------
// qpht_seq
// Request sequencer: clearing pass, serial key modulo, probe walk and result
// register, all modular sums through one shared modular adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpht_seq #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  qpht_pkg::req_t                req_i,
  input  logic [$clog2(MAX_SLOTS):0]    cap_i,
  output logic                          busy_o,
  output logic                          done_o,
  output qpht_pkg::res_t                res_o,
  output qpht_pkg::store_wr_t           wr_o,
  output logic [$clog2(MAX_SLOTS)-1:0]  addr_o,
  output logic [qpht_pkg::KEY_W-1:0]    wkey_o,
  input  logic [qpht_pkg::TAG_W-1:0]    rd_tag_i,
  input  logic [qpht_pkg::KEY_W-1:0]    rd_key_i
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = IW + 1;
  localparam logic [IW-1:0] CLR_LAST = IW'(MAX_SLOTS - 1);

  qpht_pkg::qpht_state_e state_q, state_d;

  logic [IW-1:0]                clr_q, clr_d;
  logic [CW-1:0]                used_q, used_d;
  logic                         done_q, done_d;
  qpht_pkg::res_t               res_q, res_d;
  logic [qpht_pkg::OP_W-1:0]    op_q, op_d;
  logic [qpht_pkg::KEY_W-1:0]   key_q, key_d;
  logic [qpht_pkg::BIT_W-1:0]   bit_q, bit_d;
  logic [CW-1:0]                idx_q, idx_d;   // remainder during the modulo
  logic [CW-1:0]                sq_q, sq_d;     // (n-1)*(n-1) mod cap
  logic [CW-1:0]                odd_q, odd_d;   // (2n-1) mod cap
  logic [CW-1:0]                n_q, n_d;       // probe number

  logic [CW-1:0] ua, ub, usum, lim;
  logic          ucin;
  logic          is_ins, immediate, chk_hit, chk_stop;

  qpht_modadd #(.W(CW)) u_add (
    .a_i   (ua),
    .b_i   (ub),
    .cin_i (ucin),
    .cap_i (cap_i),
    .sum_o (usum)
  );

  assign lim    = (cap_i > CW'(1)) ? cap_i - CW'(1) : CW'(1);
  assign is_ins = (op_q == qpht_pkg::OP_INSERT);

  // unknown op and insert into a full table answer straight away
  assign immediate = (req_i.operation != qpht_pkg::OP_INSERT &&
                      req_i.operation != qpht_pkg::OP_SEARCH &&
                      req_i.operation != qpht_pkg::OP_REMOVE) ||
                     (req_i.operation == qpht_pkg::OP_INSERT && used_q >= cap_i);

  assign chk_hit  = is_ins ? (rd_tag_i != qpht_pkg::TAG_USED)
                           : (rd_tag_i == qpht_pkg::TAG_USED && rd_key_i == key_q);
  assign chk_stop = (!is_ins && rd_tag_i == qpht_pkg::TAG_EMPTY) || (n_q == lim);

  // shared adder operand select
  always_comb begin
    ua   = '0;
    ub   = '0;
    ucin = 1'b0;
    case (state_q)
      qpht_pkg::QPHT_DIV: begin
        ua   = idx_q;
        ub   = idx_q;
        ucin = key_q[bit_q];
      end
      qpht_pkg::QPHT_READ: begin
        ua   = odd_q;
        ub   = CW'(1);
        ucin = 1'b1;
      end
      qpht_pkg::QPHT_CHECK: begin
        ua = sq_q;
        ub = odd_q;
      end
      qpht_pkg::QPHT_ADV: begin
        ua = idx_q;
        ub = sq_q;
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qpht_pkg::QPHT_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = qpht_pkg::QPHT_IDLE;
      end
      qpht_pkg::QPHT_IDLE: begin
        if (start_i && !immediate) state_d = qpht_pkg::QPHT_DIV;
      end
      qpht_pkg::QPHT_DIV: begin
        if (bit_q == '0) state_d = qpht_pkg::QPHT_READ;
      end
      qpht_pkg::QPHT_READ: begin
        state_d = qpht_pkg::QPHT_CHECK;
      end
      qpht_pkg::QPHT_CHECK: begin
        state_d = (chk_hit || chk_stop) ? qpht_pkg::QPHT_IDLE : qpht_pkg::QPHT_ADV;
      end
      qpht_pkg::QPHT_ADV: begin
        state_d = qpht_pkg::QPHT_READ;
      end
      default: begin
        state_d = qpht_pkg::QPHT_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_d  = clr_q;
    used_d = used_q;
    done_d = 1'b0;
    res_d  = res_q;
    op_d   = op_q;
    key_d  = key_q;
    bit_d  = bit_q;
    idx_d  = idx_q;
    sq_d   = sq_q;
    odd_d  = odd_q;
    n_d    = n_q;
    wr_o   = '0;
    addr_o = idx_q[IW-1:0];
    case (state_q)
      qpht_pkg::QPHT_CLEAR: begin
        addr_o     = clr_q;
        wr_o.tag_we = 1'b1;
        wr_o.tag    = qpht_pkg::TAG_EMPTY;
        clr_d      = clr_q + IW'(1);
      end
      qpht_pkg::QPHT_IDLE: begin
        if (start_i) begin
          op_d  = req_i.operation;
          key_d = req_i.key;
          bit_d = qpht_pkg::KEY_MSB;
          idx_d = '0;
          sq_d  = '0;
          odd_d = cap_i - CW'(1);  // -1: the first +2 lands on 1
          n_d   = CW'(1);
          if (immediate) begin
            done_d           = 1'b1;
            res_d.status     = (req_i.operation == qpht_pkg::OP_INSERT) ?
                               qpht_pkg::STAT_FULL : qpht_pkg::STAT_NOT_FOUND;
            res_d.slot_index = '0;
            res_d.occupied   = qpht_pkg::OCC_W'(used_q);
          end
        end
      end
      qpht_pkg::QPHT_DIV: begin
        idx_d = usum;
        bit_d = bit_q - qpht_pkg::BIT_W'(1);
      end
      qpht_pkg::QPHT_READ: begin
        odd_d = usum;
      end
      qpht_pkg::QPHT_CHECK: begin
        if (chk_hit) begin
          if (is_ins) begin
            wr_o.tag_we = 1'b1;
            wr_o.key_we = 1'b1;
            wr_o.tag    = qpht_pkg::TAG_USED;
            used_d      = used_q + CW'(1);
          end else if (op_q == qpht_pkg::OP_REMOVE) begin
            wr_o.tag_we = 1'b1;
            wr_o.tag    = qpht_pkg::TAG_DELETED;
            if (used_q != '0) used_d = used_q - CW'(1);
          end
          done_d           = 1'b1;
          res_d.status     = qpht_pkg::STAT_OK;
          res_d.slot_index = qpht_pkg::SLOT_W'(idx_q);
          res_d.occupied   = qpht_pkg::OCC_W'(used_d);
        end else if (chk_stop) begin
          done_d           = 1'b1;
          res_d.status     = is_ins ? qpht_pkg::STAT_FULL : qpht_pkg::STAT_NOT_FOUND;
          res_d.slot_index = '0;
          res_d.occupied   = qpht_pkg::OCC_W'(used_q);
        end else begin
          sq_d = usum;
          n_d  = n_q + CW'(1);
        end
      end
      qpht_pkg::QPHT_ADV: begin
        idx_d = usum;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qpht_pkg::QPHT_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    op_q  <= op_d;
    key_q <= key_d;
    bit_q <= bit_d;
    idx_q <= idx_d;
    sq_q  <= sq_d;
    odd_q <= odd_d;
    n_q   <= n_d;
  end

  assign busy_o = (state_q != qpht_pkg::QPHT_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;
  assign wkey_o = key_q;

endmodule

>>> hw/rtl/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table with quadratic probing: insert, search, remove.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Its result shows
// on res_o for exactly one cycle with done_o high; there is no back-pressure,
// so the receiver must take it then. A request holds busy through a bit-serial
// key modulo and then its probes, each a memory read, a tag check and a step
// of the square offset, the last probe ending at its tag check. The result
// shows in the same cycle that busy drops. All modular sums go through one
// shared modular adder. An unknown operation, or an insert while the table
// is full, answers in the cycle after acceptance. After reset the block clears
// every slot of the tag memory, with busy_o high; slot_count writes are taken
// at any time but must only be made while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "quadratic_probe_hash_table_assert.svh"

module quadratic_probe_hash_table #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: slot_count
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [qpht_pkg::CFG_W-1:0] cfg_wdata_i,
  // request side
  input  logic                       start_i,
  output logic                       busy_o,
  input  qpht_pkg::req_t             req_i,
  // result side
  output logic                       done_o,
  output qpht_pkg::res_t             res_o
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = IW + 1;

  logic [qpht_pkg::CFG_W-1:0] slot_count_q, slot_count_d;
  logic [CW-1:0]              cap;

  qpht_pkg::store_wr_t        wr;
  logic [IW-1:0]              addr;
  logic [qpht_pkg::KEY_W-1:0] wkey;
  logic [qpht_pkg::TAG_W-1:0] rd_tag;
  logic [qpht_pkg::KEY_W-1:0] rd_key;

  // config register is always writable
  assign cfg_ready_o  = 1'b1;
  assign slot_count_d = (cfg_valid_i && cfg_ready_o) ? cfg_wdata_i : slot_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= qpht_pkg::CFG_RESET;
    end else begin
      slot_count_q <= slot_count_d;
    end
  end

  // working capacity: zero acts as one, clamp at the store depth
  always_comb begin
    if (slot_count_q == '0) begin
      cap = CW'(1);
    end else if (32'(slot_count_q) > 32'(MAX_SLOTS)) begin
      cap = CW'(MAX_SLOTS);
    end else begin
      cap = CW'(slot_count_q);
    end
  end

  qpht_seq #(.MAX_SLOTS(MAX_SLOTS)) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .req_i    (req_i),
    .cap_i    (cap),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .res_o    (res_o),
    .wr_o     (wr),
    .addr_o   (addr),
    .wkey_o   (wkey),
    .rd_tag_i (rd_tag),
    .rd_key_i (rd_key)
  );

  qpht_store #(.DEPTH(MAX_SLOTS), .AW(IW)) u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .addr_i   (addr),
    .wkey_i   (wkey),
    .rd_tag_o (rd_tag),
    .rd_key_o (rd_key)
  );

  // a result always leaves the block idle
  `QPHT_ASSERT(a_done_idle, done_o |-> !busy_o, "result strobe while busy")

  // an accepted request either starts a walk or answers at once
  `QPHT_ASSERT_NEXT(a_start_acts, start_i && !busy_o, busy_o || done_o, "request dropped")

  // a failed request reports slot zero
  `QPHT_ASSERT(a_fail_slot,
               done_o && res_o.status != qpht_pkg::STAT_OK |-> res_o.slot_index == '0,
               "slot on failure")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: quadratic probe hash table testbench
// Drives insert, search and remove requests through the command port and
// checks each answer against an in-bench copy of the slot store. It runs
// through a range of slot_count settings: one, zero, the top of the register,
// a shrink while entries are held, and several odd and even sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import qpht_pkg::*;

  localparam int          TABLE_SLOTS = 1024;
  // Slowest plausible run stays well inside the limit: about 1600 requests on
  // small tables, a few dozen long walks on the full 1024-slot table and the
  // clearing pass after reset.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // spare encoding of the request kind; the block must treat it as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic [KEY_W-1:0] key_q_t[$];

  // --------------------------------------------------------------------------
  // Slot store mirror and answer checker
  // --------------------------------------------------------------------------
  class hash_table_scoreboard;
    logic [KEY_W-1:0] slot_key[TABLE_SLOTS];
    logic [TAG_W-1:0] slot_tag[TABLE_SLOTS];
    int unsigned      in_use;
    logic [CFG_W-1:0] slot_count;
    res_t             answers_due[$];
    int unsigned      errors;

    function new();
      in_use     = 0;
      errors     = 0;
      slot_count = CFG_RESET;
      foreach (slot_tag[i]) slot_tag[i] = TAG_EMPTY;
      foreach (slot_key[i]) slot_key[i] = '0;
    endfunction

    // out-of-range register values are clamped into 1..TABLE_SLOTS
    function int unsigned capacity();
      if (slot_count == 0) return 1;
      if (slot_count > TABLE_SLOTS) return TABLE_SLOTS;
      return slot_count;
    endfunction

    // walk for a key: deleted slots are passed over, an empty slot ends it
    function bit find_key(input logic [KEY_W-1:0] k, input int unsigned cap,
                          output int unsigned where);
      int unsigned idx;
      int unsigned lim;
      idx   = k % cap;
      lim   = (cap > 1) ? cap - 1 : 1;
      where = 0;
      for (int unsigned n = 1; n <= lim; n++) begin
        if (slot_tag[idx] == TAG_EMPTY) return 0;
        if (slot_tag[idx] == TAG_USED && slot_key[idx] == k) begin
          where = idx;
          return 1;
        end
        idx = (idx + n * n) % cap;
      end
      return 0;
    endfunction

    // apply one accepted request to the mirror and queue the answer it owes
    function void note_request(req_t r);
      res_t        ans;
      int unsigned cap;
      int unsigned idx;
      int unsigned lim;
      int unsigned where;
      cap            = capacity();
      ans.status     = STAT_NOT_FOUND;
      ans.slot_index = '0;
      case (r.operation)
        OP_INSERT: begin
          ans.status = STAT_FULL;
          if (in_use < cap) begin
            idx = r.key % cap;
            lim = (cap > 1) ? cap - 1 : 1;
            for (int unsigned n = 1; n <= lim; n++) begin
              if (slot_tag[idx] != TAG_USED) begin
                slot_tag[idx]  = TAG_USED;
                slot_key[idx]  = r.key;
                in_use++;
                ans.status     = STAT_OK;
                ans.slot_index = SLOT_W'(idx);
                break;
              end
              idx = (idx + n * n) % cap;
            end
          end
        end
        OP_SEARCH: begin
          if (find_key(r.key, cap, where)) begin
            ans.status     = STAT_OK;
            ans.slot_index = SLOT_W'(where);
          end
        end
        OP_REMOVE: begin
          if (find_key(r.key, cap, where)) begin
            slot_tag[where] = TAG_DELETED;
            if (in_use > 0) in_use--;
            ans.status      = STAT_OK;
            ans.slot_index  = SLOT_W'(where);
          end
        end
        default: ;
      endcase
      ans.occupied = OCC_W'(in_use);
      answers_due.push_back(ans);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (answers_due.size() == 0) begin
        $error("unexpected result: status %0d slot_index %0d occupied %0d",
               got.status, got.slot_index, got.occupied);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
        errors++;
      end
      if (got.occupied !== want.occupied) begin
        $error("occupied: expected %0d, actual %0d", want.occupied, got.occupied);
        errors++;
      end
    endfunction

    // keys held in reachable slots, one entry per copy
    function key_q_t live_keys();
      key_q_t found;
      for (int unsigned s = 0; s < capacity(); s++)
        if (slot_tag[s] == TAG_USED) found.push_back(slot_key[s]);
      return found;
    endfunction

    function bit pick_live_key(output logic [KEY_W-1:0] k);
      key_q_t found;
      found = live_keys();
      k     = '0;
      if (found.size() == 0) return 0;
      k = found[$urandom_range(found.size() - 1)];
      return 1;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  req_t                 req_i       = '0;
  logic                 done_o;
  res_t                 res_o;

  hash_table_scoreboard sb = new();
  int unsigned          cycles = 0;

  always #5 clk_i = ~clk_i;

  quadratic_probe_hash_table #(
    .MAX_SLOTS (TABLE_SLOTS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  // Results are sampled mid-cycle: the strobe lasts exactly one cycle, and the
  // request it answers was noted at an earlier rising edge, so the order of
  // note and check never hangs on scheduling within a time step.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // start_i is left high on return so back-to-back requests need no second
  // assignment in the same step; callers lower it when they want a gap.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    req_t r;
    r.operation = op;
    r.key       = k;
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic pause(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // every request owes one answer, so an empty queue plus busy low means idle;
  // the do-while always steps the clock before the next drive
  task automatic wait_answers();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.answers_due.size() != 0 || busy_o);
  endtask

  task automatic write_slot_count(input logic [CFG_W-1:0] v);
    wait_answers();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.slot_count = v;
    cfg_valid_i <= 1'b0;
  endtask

  // remove every reachable key so the next size starts from a clean table
  task automatic drain_table();
    key_q_t held;
    wait_answers();
    held = sb.live_keys();
    foreach (held[i]) send_request(OP_REMOVE, held[i]);
    wait_answers();
  endtask

  // keys: full-range, small, top of range, and same-home chains for collisions
  function automatic logic [KEY_W-1:0] any_key();
    int unsigned cap;
    cap = sb.capacity();
    case ($urandom_range(4))
      0:       return KEY_W'($urandom());
      1:       return KEY_W'($urandom_range(63));
      2:       return KEY_W'({1'b0, {KEY_W{1'b1}}} - $urandom_range(255));
      default: return KEY_W'($urandom_range(3) + cap * $urandom_range(2000));
    endcase
  endfunction

  // mostly well-formed traffic: searches and removes aim at live keys
  task automatic random_request();
    int unsigned       roll;
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  k;
    roll = $urandom_range(99);
    if (roll < 45) begin
      op = OP_INSERT;
      k  = any_key();
    end else if (roll < 94) begin
      op = (roll < 70) ? OP_SEARCH : OP_REMOVE;
      if ($urandom_range(9) >= 8 || !sb.pick_live_key(k)) k = any_key();
    end else begin
      op = OP_W'($urandom_range(3));
      k  = KEY_W'($urandom());
    end
    send_request(op, k);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size, input int unsigned count,
                           input bit with_gaps, input bit drain_after);
    bit gaps_now;
    write_slot_count(size);
    gaps_now = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      // gaps come and go in stretches so some runs are fully back-to-back
      if (i % 40 == 0) gaps_now = with_gaps && $urandom_range(1);
      if (gaps_now && $urandom_range(99) < 25) pause($urandom_range(1, 9));
      else if (with_gaps && $urandom_range(149) == 0) wait_answers();
      random_request();
    end
    if (drain_after) drain_table();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, on the reset size of 11; the first request also waits out
    // the clearing pass
    send_request(OP_SEARCH, 31'd5);            // empty table: stops at home
    send_request(OP_REMOVE, 31'd5);
    send_request(OP_INSERT, 31'd0);
    send_request(OP_INSERT, 31'h7FFF_FFFF);
    send_request(OP_INSERT, 31'd11);           // same home as 0
    send_request(OP_INSERT, 31'd22);           // second step of the chain
    send_request(OP_SEARCH, 31'd22);
    send_request(OP_REMOVE, 31'd11);           // leaves a tombstone mid-chain
    send_request(OP_SEARCH, 31'd22);           // walks over the tombstone
    send_request(OP_SEARCH, 31'd11);
    send_request(OP_INSERT, 31'd33);           // reuses the tombstone
    send_request(OP_INSERT, 31'd0);            // duplicate is stored again
    send_request(OP_UNUSED, 31'h7FFF_FFFF);
    send_request(OP_UNUSED, 31'd0);
    send_request(OP_SEARCH, 31'h7FFF_FFFF);
    send_request(OP_REMOVE, 31'h7FFF_FFFF);
    send_request(OP_SEARCH, 31'h5555_5555);
    send_request(OP_SEARCH, 31'h2AAA_AAAA);
    drain_table();

    // random, across sizes; single-slot and clamped settings included
    run_phase(11'd11,   200, 1'b1, 1'b1);
    run_phase(11'd1,     60, 1'b1, 1'b1);
    run_phase(11'd2,     70, 1'b1, 1'b1);
    run_phase(11'd0,     40, 1'b1, 1'b1);
    run_phase(11'd7,    200, 1'b1, 1'b1);
    // shrink with entries held, then grow back so they are reachable again
    run_phase(11'd16,   180, 1'b1, 1'b0);
    run_phase(11'd4,     40, 1'b1, 1'b0);
    run_phase(11'd16,    20, 1'b1, 1'b1);
    run_phase(11'd1024,  40, 1'b1, 1'b1);
    run_phase(11'd2047,  30, 1'b1, 1'b1);
    run_phase(11'd13,   200, 1'b1, 1'b1);
    run_phase(11'd37,   200, 1'b1, 1'b1);
    run_phase(11'd64,   150, 1'b0, 1'b0);

    wait_answers();
    // a stray strobe would show within one full walk on the current size
    repeat (300) @(posedge clk_i);
    if (sb.answers_due.size() != 0) begin
      $error("%0d answers never arrived", sb.answers_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
